[rtl/core/flra_pkg.sv]
// Shared types, codes and constants of the free-list reuse allocator.
`timescale 1ns / 1ps

package flra_pkg;

	// Default sizing handed to the top level parameters
	localparam int STACK_DEPTH_DEF = 64;
	localparam int ALIGN_BYTES_DEF = 8;
	localparam int MIN_PIECE_DEF   = 24;

	// Stream payload widths
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 3;

	// Item kinds on the input tuser
	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_RETURN = 1'b1;

	// Caller flag: granted memory need not be zeroed
	localparam logic DIRTY_OK = 1'b1;

	// Result status codes
	localparam logic [2:0] ST_GRANTED   = 3'd0;
	localparam logic [2:0] ST_FALLBACK  = 3'd1;
	localparam logic [2:0] ST_KEPT      = 3'd2;
	localparam logic [2:0] ST_TOO_SMALL = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NULL      = 3'd5;

	// Alignment unit: steps after accept until the rounded size is ready
	localparam int ALIGN_STEPS = 2;

	// Controller to datapath
	typedef struct packed {
		logic       load_in;    // latch the accepted item
		logic       pop;        // read top entry, decrement count
		logic       push_in;    // push the returned piece
		logic       push_tail;  // push the split-off tail
		logic       res_load;   // load the output register
		logic [2:0] res_code;   // status for the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_return;
		logic addr_zero;
		logic too_small;
		logic full;
		logic empty;
		logic fits;
		logic align_done;
		logic split_ok;
		logic out_free;
	} sts_t;

endpackage

[rtl/core/flra_dp.sv]
// Datapath of the allocator: item latches, piece stack, alignment unit, result register.
`timescale 1ns / 1ps

module flra_dp #(
	parameter int STACK_DEPTH = flra_pkg::STACK_DEPTH_DEF,
	parameter int ALIGN_BYTES = flra_pkg::ALIGN_BYTES_DEF,
	parameter int MIN_PIECE   = flra_pkg::MIN_PIECE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [flra_pkg::IN_TDATA_W-1:0]  in_tdata,
	input  logic [flra_pkg::IN_TUSER_W-1:0]  in_tuser,
	input  flra_pkg::cmd_t                   cmd,
	output flra_pkg::sts_t                   sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [flra_pkg::OUT_TDATA_W-1:0] out_tdata,
	output logic [flra_pkg::OUT_TUSER_W-1:0] out_tuser
);
	import flra_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AL = $clog2(ALIGN_BYTES);
	localparam int RW = AL + 1;
	localparam int SW = $clog2(ALIGN_STEPS + 1);
	// ceil(2^(32+AL) / ALIGN_BYTES): exact quotient for every 32-bit size
	localparam logic [63:0] RECIP_W = ((64'd1 << (32 + AL)) + 64'(ALIGN_BYTES - 1))
		/ 64'(ALIGN_BYTES);
	localparam logic [32:0] RECIP   = 33'(RECIP_W);

	// Latched item
	logic        kind_q;
	logic [31:0] addr_q;
	logic [31:0] size_q;
	logic        dirty_q;

	// Stack
	logic [63:0]   stack_q [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [63:0]   rd_q;
	logic [31:0]   rd_addr;
	logic [31:0]   rd_size;
	logic          wr_en;
	logic [63:0]   wr_data;

	// Alignment
	logic [64:0]   prod_q;
	logic [31:0]   quot;
	logic [31:0]   rem_full;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] pad;
	logic [SW-1:0] step_q;
	logic [32:0]   aligned_q;
	logic [31:0]   tail_addr;
	logic [31:0]   tail_size;

	// Result register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_addr_q;
	logic        out_clear_q;

	// Item latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q  <= in_tuser[0];
			addr_q  <= in_tdata[31:0];
			size_q  <= in_tdata[63:32];
			dirty_q <= in_tdata[64];
		end
	end

	assign cnt_m1  = count_q - CW'(1);
	assign rd_addr = rd_q[31:0];
	assign rd_size = rd_q[63:32];

	// Stack write: returned piece or split tail into the slot above the current top
	assign wr_en     = cmd.push_in | cmd.push_tail;
	assign tail_addr = rd_addr + aligned_q[31:0];
	assign tail_size = rd_size - aligned_q[31:0];
	assign wr_data   = cmd.push_tail ? {tail_size, tail_addr} : {size_q, addr_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_q[count_q[AW-1:0]] <= wr_data;
		end
		if (cmd.pop) begin
			rd_q <= stack_q[cnt_m1[AW-1:0]];
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Remainder of size by the alignment from the reciprocal product
	assign quot     = 32'(prod_q >> (32 + AL));
	assign rem_full = size_q - quot * 32'(ALIGN_BYTES);

	assign pad = (rem_q == '0) ? '0 : (RW'(ALIGN_BYTES) - rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_in) begin
			step_q <= '0;
		end else if (step_q < SW'(ALIGN_STEPS)) begin
			step_q <= step_q + SW'(1);
		end
	end

	// Product at accept, remainder next cycle, rounded size after that
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			prod_q <= 65'(in_tdata[63:32]) * 65'(RECIP);
		end else if (step_q == SW'(0)) begin
			rem_q <= rem_full[RW-1:0];
		end else if (step_q == SW'(1)) begin
			aligned_q <= {1'b0, size_q} + 33'(pad);
		end
	end

	// Status to the controller
	assign sts.is_return  = (kind_q == KIND_RETURN);
	assign sts.addr_zero  = (addr_q == '0);
	assign sts.too_small  = (size_q < 32'(MIN_PIECE));
	assign sts.full       = (count_q == CW'(STACK_DEPTH));
	assign sts.empty      = (count_q == '0);
	assign sts.fits       = (rd_size >= size_q);
	assign sts.align_done = (step_q == SW'(ALIGN_STEPS));
	assign sts.split_ok   = ({2'b0, rd_size} >= ({1'b0, aligned_q} + 34'(MIN_PIECE)));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_code;
			out_addr_q   <= (cmd.res_code == ST_GRANTED) ? rd_addr : '0;
			out_clear_q  <= (cmd.res_code == ST_GRANTED) && (dirty_q != DIRTY_OK);
		end
	end

	assign out_valid = out_valid_q;
	assign out_tdata = {7'b0, out_clear_q, out_addr_q};
	assign out_tuser = out_status_q;

endmodule

[rtl/core/flra_ctrl.sv]
// Controller state machine of the allocator.
`timescale 1ns / 1ps

module flra_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  flra_pkg::sts_t sts,
	output flra_pkg::cmd_t cmd
);
	import flra_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_POP      = 3'd2;
	localparam logic [2:0] S_FIT      = 3'd3;
	localparam logic [2:0] S_RESULT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] code_q;
	logic [2:0] code_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		code_d        = code_q;
		cmd           = '0;
		cmd.res_code  = code_q;
		cmd.load_in   = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_RESULT;
				if (sts.is_return) begin
					priority if (sts.addr_zero) begin
						code_d = ST_NULL;
					end else if (sts.too_small) begin
						code_d = ST_TOO_SMALL;
					end else if (sts.full) begin
						code_d = ST_FULL;
					end else begin
						code_d      = ST_KEPT;
						cmd.push_in = 1'b1;
					end
				end else if (sts.empty) begin
					code_d = ST_FALLBACK;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				// popped entry is in the read register; too small ones are dropped
				priority if (sts.fits) begin
					state_d = S_FIT;
				end else if (sts.empty) begin
					code_d  = ST_FALLBACK;
					state_d = S_RESULT;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			S_FIT: begin
				if (sts.align_done) begin
					cmd.push_tail = sts.split_ok;
					code_d        = ST_GRANTED;
					state_d       = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_GRANTED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

[rtl/core/free_list_reuse_allocator_unit.sv]
// Top level of the LIFO free-list reuse allocator.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: addr, size, dirty; tuser: kind
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: grant addr, clear; tuser: status
//
// One item at a time. A return, or an allocate on an empty stack, goes from the dispatch
// state to the result state. An allocate that fits passes dispatch, pop (one stack read
// per cycle while too-small pieces are popped), fit and result; a fall back after pops
// goes from pop to result. The aligned size is ready before it is first needed.
// Reset clears the entry count, the alignment step counter, the output valid flag and
// the controller. The result waits in an output register; a stalled m_axis holds the
// result and the next item is taken meanwhile, finishing only when the register frees.
`timescale 1ns / 1ps

module free_list_reuse_allocator_unit #(
	parameter int STACK_DEPTH = flra_pkg::STACK_DEPTH_DEF,
	parameter int ALIGN_BYTES = flra_pkg::ALIGN_BYTES_DEF,
	parameter int MIN_PIECE   = flra_pkg::MIN_PIECE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] piece_addr, [63:32] byte_size, [64] keep_dirty, [71:65] zero
	input  logic [flra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] kind
	input  logic [flra_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] grant_addr, [32] clear_needed, [39:33] zero
	output logic [flra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [2:0] status
	output logic [flra_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import flra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller
	flra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	flra_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.ALIGN_BYTES (ALIGN_BYTES),
		.MIN_PIECE   (MIN_PIECE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

endmodule

[rtl/core/flra_chk.sv]
// Port-level checks of the allocator, bound to the top level.
`timescale 1ns / 1ps

module flra_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [flra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [flra_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [flra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [flra_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import flra_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= ST_NULL))
		else $error("undefined status code");

	// Address and clear flag only come with a grant
	a_grant_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_GRANTED) |-> (m_axis_tdata == '0))
		else $error("payload set without a grant");

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

endmodule

bind free_list_reuse_allocator_unit flra_chk u_flra_chk (.*);
